FILE: sv/lpg_pkg.sv
package lpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int PIX_W      = 12;
  localparam int FW_W       = 12;
  localparam int ADDR_W     = 24;
  localparam int COLOR_W    = 32;
  localparam int ERR_W      = COORD_BITS + 3;
  localparam int IN_DATA_W  = 4 * PIX_W + COLOR_W;
  localparam int OUT_DATA_W = ADDR_W + 2 * PIX_W + COLOR_W;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);

  typedef enum logic {
    FUNC_START   = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_t;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                vld;
    coord_t              x;
    coord_t              y;
    logic [COLOR_W-1:0]  color;
    logic                last;
  } pix_t;

  function automatic coord_t step_coord(input coord_t c, input logic neg);
    coord_t r;
    r = neg ? c - coord_t'(1) : c + coord_t'(1);
    return r;
  endfunction

endpackage

FILE: sv/line_pixel_generator.sv
// The input transfer updates the line state and fills the middle register; the
// address multiply then fills the output register. Throughput: one item per
// cycle unless the output stalls; the 12x12 address multiply sets the clock path.
// Reset (rst_n low, synchronous): no line is active, both pipeline stages are empty
// and frame_width returns to 640.
module line_pixel_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // start_x, start_y, end_x, end_y, line_color
  input  logic [lpg_pkg::IN_DATA_W-1:0]   in_tdata,
  // func
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // pixel_address, pixel_x, pixel_y, pixel_color
  output logic [lpg_pkg::OUT_DATA_W-1:0]  out_tdata,
  // pixel_valid
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpg_pkg::FW_W-1:0]        cfg_data
);
  import lpg_pkg::*;

  logic [FW_W-1:0]   fw_r;
  coord_t            col_r, col_nxt;
  coord_t            row_r, row_nxt;
  coord_t            adx_r, adx_nxt;
  coord_t            ady_r, ady_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  coord_t            steps_r, steps_nxt;
  logic              col_neg_r, col_neg_nxt;
  logic              row_neg_r, row_neg_nxt;
  logic              major_col_r, major_col_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic              busy_r, busy_nxt;

  logic              mid_vld_r;
  pix_t              mid_pix_r, mid_pix_nxt;
  logic              out_vld_r;
  pix_t              out_pix_r;
  logic [ADDR_W-1:0] out_addr_r, addr_nxt;

  logic              accept, out_adv, mid_adv;
  coord_t            sx, sy, ex, ey;
  logic              s_col_neg, s_row_neg, s_major_col;
  coord_t            s_adx, s_ady, s_major, s_minor;
  logic [ERR_W-1:0]  s_err;
  coord_t            a_major, a_minor, col_adv, row_adv, steps_adv;
  logic              minor_step;
  logic [ERR_W-1:0]  err_adv;
  logic [COORD_BITS+FW_W-1:0] prod;

  assign out_adv   = !out_vld_r || out_tready;
  assign mid_adv   = !mid_vld_r || out_adv;
  assign in_tready = mid_adv;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign sx = COORD_BITS'(in_tdata[PIX_W-1:0]);
  assign sy = COORD_BITS'(in_tdata[2*PIX_W-1:PIX_W]);
  assign ex = COORD_BITS'(in_tdata[3*PIX_W-1:2*PIX_W]);
  assign ey = COORD_BITS'(in_tdata[4*PIX_W-1:3*PIX_W]);

  always_comb begin
    s_col_neg   = ex < sx;
    s_row_neg   = ey < sy;
    s_adx       = s_col_neg ? sx - ex : ex - sx;
    s_ady       = s_row_neg ? sy - ey : ey - sy;
    s_major_col = s_adx > s_ady;
    s_major     = s_major_col ? s_adx : s_ady;
    s_minor     = s_major_col ? s_ady : s_adx;
    s_err       = ERR_W'({s_minor, 1'b0}) - ERR_W'(s_major);

    a_major    = major_col_r ? adx_r : ady_r;
    a_minor    = major_col_r ? ady_r : adx_r;
    minor_step = !err_r[ERR_W-1];
    err_adv    = minor_step ?
                 err_r + ERR_W'({a_minor, 1'b0}) - ERR_W'({a_major, 1'b0}) :
                 err_r + ERR_W'({a_minor, 1'b0});
    col_adv    = (major_col_r || minor_step) ? step_coord(col_r, col_neg_r) : col_r;
    row_adv    = (!major_col_r || minor_step) ? step_coord(row_r, row_neg_r) : row_r;
    steps_adv  = steps_r - coord_t'(1);

    col_nxt       = col_r;
    row_nxt       = row_r;
    adx_nxt       = adx_r;
    ady_nxt       = ady_r;
    err_nxt       = err_r;
    steps_nxt     = steps_r;
    col_neg_nxt   = col_neg_r;
    row_neg_nxt   = row_neg_r;
    major_col_nxt = major_col_r;
    color_nxt     = color_r;
    busy_nxt      = busy_r;
    mid_pix_nxt   = '0;

    if (accept) begin
      if (func_t'(in_tuser) == FUNC_START) begin
        col_nxt       = sx;
        row_nxt       = sy;
        adx_nxt       = s_adx;
        ady_nxt       = s_ady;
        err_nxt       = s_err;
        steps_nxt     = s_major;
        col_neg_nxt   = s_col_neg;
        row_neg_nxt   = s_row_neg;
        major_col_nxt = s_major_col;
        color_nxt     = in_tdata[IN_DATA_W-1:4*PIX_W];
        busy_nxt      = s_major != '0;
        mid_pix_nxt   = '{vld: 1'b1, x: sx, y: sy,
                          color: in_tdata[IN_DATA_W-1:4*PIX_W], last: s_major == '0};
      end else if (busy_r) begin
        col_nxt     = col_adv;
        row_nxt     = row_adv;
        err_nxt     = err_adv;
        steps_nxt   = steps_adv;
        busy_nxt    = steps_adv != '0;
        mid_pix_nxt = '{vld: 1'b1, x: col_adv, y: row_adv,
                        color: color_r, last: steps_adv == '0};
      end
    end

    prod     = (COORD_BITS+FW_W)'(mid_pix_r.y) * (COORD_BITS+FW_W)'(fw_r);
    addr_nxt = ADDR_W'(prod) + ADDR_W'(mid_pix_r.x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r        <= FW_RESET;
      col_r       <= '0;
      row_r       <= '0;
      adx_r       <= '0;
      ady_r       <= '0;
      err_r       <= '0;
      steps_r     <= '0;
      col_neg_r   <= 1'b0;
      row_neg_r   <= 1'b0;
      major_col_r <= 1'b0;
      color_r     <= '0;
      busy_r      <= 1'b0;
      mid_vld_r   <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fw_r <= cfg_data;
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      adx_r       <= adx_nxt;
      ady_r       <= ady_nxt;
      err_r       <= err_nxt;
      steps_r     <= steps_nxt;
      col_neg_r   <= col_neg_nxt;
      row_neg_r   <= row_neg_nxt;
      major_col_r <= major_col_nxt;
      color_r     <= color_nxt;
      busy_r      <= busy_nxt;
      if (mid_adv) begin
        mid_vld_r <= accept;
      end
      if (out_adv) begin
        out_vld_r <= mid_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv) begin
      mid_pix_r <= mid_pix_nxt;
    end
    if (out_adv && mid_vld_r) begin
      out_pix_r  <= mid_pix_r;
      out_addr_r <= addr_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_pix_r.vld;
  assign out_tlast  = out_pix_r.last;
  assign out_tdata  = {out_pix_r.color, PIX_W'(out_pix_r.y), PIX_W'(out_pix_r.x),
                       out_addr_r};

endmodule

FILE: sv/lpg_checker.sv
module lpg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lpg_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);
  import lpg_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // The pipeline drains after reset.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // An advance without an active line gives an all-zero result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0 && !out_tlast)
    else $error("invalid pixel carries data");

  // A taken result frees room, so input is never refused then.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output side is ready");

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
